// File: rtl/bsp_pkg.sv
// shared types and constants of the box screen projection block
`default_nettype none
package bsp_pkg;

    localparam int IN_W    = 232;
    localparam int OUT_W   = 136;
    localparam int VP_W    = 14;
    localparam int MINSZ_W = 23;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 23;

    localparam logic [VP_W-1:0]    VP_W_RST  = 14'd1920;
    localparam logic [VP_W-1:0]    VP_H_RST  = 14'd1080;
    localparam logic [MINSZ_W-1:0] MINSZ_RST = 23'd131072;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_VP_WIDTH  = 2'd0,
        CFG_VP_HEIGHT = 2'd1,
        CFG_MIN_SIZE  = 2'd2
    } bsp_cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_LOAD_MV   = 2'd0,
        MODE_LOAD_PROJ = 2'd1,
        MODE_BOX       = 2'd2,
        MODE_BOX_ALT   = 2'd3
    } bsp_mode_t;

    typedef enum logic [1:0] {
        STAT_LOADED = 2'd0,
        STAT_VALID  = 2'd1,
        STAT_NONE   = 2'd2,
        STAT_SMALL  = 2'd3
    } bsp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CSET,
        ST_MUL,
        ST_ACC,
        ST_WCHK,
        ST_DSTART,
        ST_DWAIT,
        ST_VMX,
        ST_VMY,
        ST_VFIN,
        ST_NEXT,
        ST_DONE,
        ST_EMIT
    } bsp_state_t;

endpackage
`default_nettype wire

// File: rtl/bsp_div.sv
// serial restoring divider on magnitudes, one quotient bit per cycle
`default_nettype none
module bsp_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dvd,
    input  wire logic [DVS_W-1:0] dvs,
    output logic                  done,
    output logic [DVD_W-1:0]      quo
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DVS_W:0]     rem_reg, rem_next;
    logic [DVD_W-1:0]   quo_reg, quo_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [DVS_W:0]     rem_sh;
    logic               take;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
        take      = rem_sh >= {1'b0, dvs_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dvd;
            dvs_next  = dvs;
        end else if (busy_reg) begin
            rem_next = take ? rem_sh - {1'b0, dvs_reg} : rem_sh;
            quo_next = {quo_reg[DVD_W-2:0], take};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

// File: rtl/box_screen_projection.sv
// box screen projection: 8 corners through two matrices, divide, viewport, min/max
// throughput: one word at a time, ready only when the sequencer is idle
// each corner uses one shared 33x33 multiplier for 32 matrix terms and 2 viewport terms
// and one serial divider for up to 3 perspective divides, one quotient bit per cycle
// reset: synchronous active-low aresetn clears both matrices and restores the three configuration registers
`default_nettype none
module box_screen_projection #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [bsp_pkg::CFG_A_W-1:0]  cfg_index,
    input  wire logic [bsp_pkg::CFG_D_W-1:0]  cfg_wdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // mode, element_index, element_value, box_min_x/y/z, box_max_x/y/z
    input  wire logic [bsp_pkg::IN_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // status, visible_corners, screen_min_x, screen_min_y, screen_max_x, screen_max_y
    output logic [bsp_pkg::OUT_W-1:0]         m_tdata
);
    import bsp_pkg::*;

    localparam int ACC_W = 66 - FRAC_BITS;
    localparam int DVD_W = 32 + FRAC_BITS;
    localparam int WEpsRaw = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam int WEps = (WEpsRaw < 1) ? 1 : WEpsRaw;
    localparam logic signed [32:0] One33 = 33'(64'd1 << FRAC_BITS);
    localparam logic [31:0] One32 = 32'(64'd1 << FRAC_BITS);

    bsp_state_t state_reg, state_next;

    logic [31:0] mv_reg [16];
    logic [31:0] mv_next [16];
    logic [31:0] pj_reg [16];
    logic [31:0] pj_next [16];
    logic [VP_W-1:0]    vw_reg, vh_reg;
    logic [MINSZ_W-1:0] minsz_reg;

    logic [2:0]  corner_reg, corner_next;
    logic [1:0]  row_reg, row_next, col_reg, col_next, axis_reg, axis_next;
    logic        stage_reg, stage_next, drop_reg, drop_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [65:0] prod_reg, prod_next;
    logic [31:0] vec_reg [4];
    logic [31:0] vec_next [4];
    logic [31:0] res_reg [4];
    logic [31:0] res_next [4];
    logic [31:0] lo_reg [3];
    logic [31:0] lo_next [3];
    logic [31:0] hi_reg [3];
    logic [31:0] hi_next [3];
    logic [31:0] ndc_reg [3];
    logic [31:0] ndc_next [3];
    logic [31:0] sx_reg, sx_next;
    logic [3:0]  vis_reg, vis_next;
    logic [31:0] mnx_reg, mnx_next, mny_reg, mny_next;
    logic [31:0] mxx_reg, mxx_next, mxy_reg, mxy_next;
    bsp_status_t status_reg, status_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p, term, half;
    logic signed [ACC_W-1:0] acc_sum;
    logic        acc_ovf;
    logic [31:0] mat_elem, w_val, c_val, c_abs, qval, sy;
    logic [32:0] w_abs;
    logic        div_start, div_done, q_neg, q_hi_zero, q_fits, half_ok;
    logic [DVD_W-1:0] div_quo;
    logic [1:0]  in_mode;
    logic [3:0]  in_idx;
    logic signed [32:0] wdx, wdy;

    bsp_div #(.DVD_W(DVD_W), .DVS_W(32)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dvd     ({c_abs, {FRAC_BITS{1'b0}}}),
        .dvs     (w_abs[31:0]),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign mul_p   = mul_a * mul_b;
    assign term    = prod_reg >>> FRAC_BITS;
    assign half    = prod_reg >>> 1;
    assign half_ok = (half[65:31] == {35{half[31]}});
    assign in_mode = s_tdata[1:0];
    assign in_idx  = s_tdata[5:2];
    assign mat_elem = stage_reg ? pj_reg[{col_reg, row_reg}] : mv_reg[{col_reg, row_reg}];
    assign acc_sum = ((col_reg == 2'd0) ? ACC_W'(0) : acc_reg)
                   + $signed(term[ACC_W-1:0]);
    assign acc_ovf = (acc_sum[ACC_W-1:31] != {(ACC_W-31){acc_sum[31]}});
    assign w_val   = res_reg[3];
    assign w_abs   = w_val[31] ? 33'(-$signed({w_val[31], w_val})) : {1'b0, w_val};
    assign c_val   = res_reg[axis_reg];
    assign c_abs   = c_val[31] ? 32'(-c_val) : c_val;
    assign q_neg   = c_val[31] ^ w_val[31];
    assign q_hi_zero = (div_quo[DVD_W-1:32] == '0);
    assign q_fits  = q_hi_zero && (!div_quo[31] || (q_neg && div_quo[30:0] == '0));
    assign qval    = q_neg ? 32'(-div_quo[31:0]) : div_quo[31:0];
    assign sy      = half[31:0];
    assign wdx     = $signed({mxx_reg[31], mxx_reg}) - $signed({mnx_reg[31], mnx_reg});
    assign wdy     = $signed({mxy_reg[31], mxy_reg}) - $signed({mny_reg[31], mny_reg});

    always_comb begin
        state_next   = state_reg;
        mv_next      = mv_reg;
        pj_next      = pj_reg;
        corner_next  = corner_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        axis_next    = axis_reg;
        stage_next   = stage_reg;
        drop_next    = drop_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        vec_next     = vec_reg;
        res_next     = res_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        ndc_next     = ndc_reg;
        sx_next      = sx_reg;
        vis_next     = vis_reg;
        mnx_next     = mnx_reg;
        mny_next     = mny_reg;
        mxx_next     = mxx_reg;
        mxy_next     = mxy_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        s_tready     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    vis_next    = '0;
                    mnx_next    = '0;
                    mny_next    = '0;
                    mxx_next    = '0;
                    mxy_next    = '0;
                    status_next = STAT_LOADED;
                    for (int k = 0; k < 3; k++) begin
                        lo_next[k] = s_tdata[38 + 32*k +: 32];
                        hi_next[k] = s_tdata[134 + 32*k +: 32];
                    end
                    case (in_mode)
                        MODE_LOAD_MV: begin
                            mv_next[in_idx] = s_tdata[37:6];
                            state_next = ST_EMIT;
                        end
                        MODE_LOAD_PROJ: begin
                            pj_next[in_idx] = s_tdata[37:6];
                            state_next = ST_EMIT;
                        end
                        default: begin
                            corner_next = '0;
                            state_next  = ST_CSET;
                        end
                    endcase
                end
            end
            ST_CSET: begin
                vec_next[0] = corner_reg[0] ? hi_reg[0] : lo_reg[0];
                vec_next[1] = corner_reg[1] ? hi_reg[1] : lo_reg[1];
                vec_next[2] = corner_reg[2] ? hi_reg[2] : lo_reg[2];
                vec_next[3] = One32;
                stage_next  = 1'b0;
                row_next    = '0;
                col_next    = '0;
                drop_next   = 1'b0;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                mul_a      = {vec_reg[col_reg][31], vec_reg[col_reg]};
                mul_b      = {mat_elem[31], mat_elem};
                prod_next  = mul_p;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_next   = acc_sum;
                col_next   = col_reg + 2'd1;
                state_next = ST_MUL;
                if (col_reg == 2'd3) begin
                    if (acc_ovf) drop_next = 1'b1;
                    res_next[row_reg] = acc_sum[31:0];
                    row_next = row_reg + 2'd1;
                    if (row_reg == 2'd3) begin
                        if (!stage_reg) begin
                            vec_next[0] = res_reg[0];
                            vec_next[1] = res_reg[1];
                            vec_next[2] = res_reg[2];
                            vec_next[3] = acc_sum[31:0];
                            stage_next  = 1'b1;
                        end else begin
                            state_next = ST_WCHK;
                        end
                    end
                end
            end
            ST_WCHK: begin
                axis_next = '0;
                if (drop_reg || w_abs < 33'(WEps) || vw_reg == '0 || vh_reg == '0)
                    state_next = ST_NEXT;
                else
                    state_next = ST_DSTART;
            end
            ST_DSTART: begin
                div_start  = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_done) begin
                    ndc_next[axis_reg] = qval;
                    axis_next = axis_reg + 2'd1;
                    if (!q_fits) begin
                        state_next = ST_NEXT;
                    end else if (axis_reg == 2'd2) begin
                        if ($signed({qval[31], qval}) < -One33 ||
                            $signed({qval[31], qval}) > One33)
                            state_next = ST_NEXT;
                        else
                            state_next = ST_VMX;
                    end else begin
                        state_next = ST_DSTART;
                    end
                end
            end
            ST_VMX: begin
                mul_a      = {19'd0, vw_reg};
                mul_b      = $signed({ndc_reg[0][31], ndc_reg[0]}) + One33;
                prod_next  = mul_p;
                state_next = ST_VMY;
            end
            ST_VMY: begin
                mul_a      = {19'd0, vh_reg};
                mul_b      = One33 - $signed({ndc_reg[1][31], ndc_reg[1]});
                prod_next  = mul_p;
                sx_next    = half[31:0];
                if (!half_ok) drop_next = 1'b1;
                state_next = ST_VFIN;
            end
            ST_VFIN: begin
                if (!drop_reg && half_ok) begin
                    vis_next = vis_reg + 4'd1;
                    if (vis_reg == '0) begin
                        mnx_next = sx_reg;
                        mxx_next = sx_reg;
                        mny_next = sy;
                        mxy_next = sy;
                    end else begin
                        if ($signed(sx_reg) < $signed(mnx_reg)) mnx_next = sx_reg;
                        if ($signed(sx_reg) > $signed(mxx_reg)) mxx_next = sx_reg;
                        if ($signed(sy) < $signed(mny_reg)) mny_next = sy;
                        if ($signed(sy) > $signed(mxy_reg)) mxy_next = sy;
                    end
                end
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if (corner_reg == 3'd7) begin
                    state_next = ST_DONE;
                end else begin
                    corner_next = corner_reg + 3'd1;
                    state_next  = ST_CSET;
                end
            end
            ST_DONE: begin
                if (vis_reg == '0)
                    status_next = STAT_NONE;
                else if (wdx < $signed({10'd0, minsz_reg}) ||
                         wdy < $signed({10'd0, minsz_reg}))
                    status_next = STAT_SMALL;
                else
                    status_next = STAT_VALID;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, mxy_reg, mxx_reg, mny_reg, mnx_reg,
                                    vis_reg, status_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            vw_reg      <= VP_W_RST;
            vh_reg      <= VP_H_RST;
            minsz_reg   <= MINSZ_RST;
            for (int i = 0; i < 16; i++) begin
                mv_reg[i] <= '0;
                pj_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            mv_reg      <= mv_next;
            pj_reg      <= pj_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_VP_WIDTH:  vw_reg    <= cfg_wdata[VP_W-1:0];
                    CFG_VP_HEIGHT: vh_reg    <= cfg_wdata[VP_W-1:0];
                    CFG_MIN_SIZE:  minsz_reg <= cfg_wdata[MINSZ_W-1:0];
                    default: ;
                endcase
            end
        end
        corner_reg <= corner_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        axis_reg   <= axis_next;
        stage_reg  <= stage_next;
        drop_reg   <= drop_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        vec_reg    <= vec_next;
        res_reg    <= res_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        ndc_reg    <= ndc_next;
        sx_reg     <= sx_next;
        vis_reg    <= vis_next;
        mnx_reg    <= mnx_next;
        mny_reg    <= mny_next;
        mxx_reg    <= mxx_next;
        mxy_reg    <= mxy_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule
`default_nettype wire

// File: rtl/bsp_checker.sv
// port-level checks of the box screen projection block and their bind
`default_nettype none
module bsp_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic [bsp_pkg::OUT_W-1:0]    m_tdata,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready
);
    import bsp_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready while a word is in work");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == STAT_LOADED || m_tdata[1:0] == STAT_NONE)
        |-> m_tdata[133:2] == '0)
        else $error("load or empty result carries a rectangle");

    a_rect: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == STAT_VALID || m_tdata[1:0] == STAT_SMALL)
        |-> m_tdata[5:2] != 4'd0 && m_tdata[5:2] <= 4'd8
            && $signed(m_tdata[101:70]) >= $signed(m_tdata[37:6])
            && $signed(m_tdata[133:102]) >= $signed(m_tdata[69:38]))
        else $error("rectangle inconsistent with its status");
endmodule

bind box_screen_projection bsp_checker u_bsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

// File: dv/bsp_checker.sv
// checker for the box screen projection block: predicts each result word and compares it
`default_nettype none
module bsp_scoreboard
    import bsp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_A_W-1:0] cfg_index,
    input  wire logic [CFG_D_W-1:0] cfg_wdata,
    input  wire logic             s_tvalid,
    input  wire logic             s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [OUT_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    pending
);
    localparam int FB = 16;
    localparam longint ONE = 64'sd1 << FB;
    localparam longint I32MAX = 64'sd2147483647;
    localparam longint I32MIN = -64'sd2147483648;

    longint mv [16];
    longint pj [16];
    longint vp_w, vp_h, min_size;
    logic [OUT_W-1:0] rect_q[$];

    function automatic bit outside32(longint v);
        return v > I32MAX || v < I32MIN;
    endfunction

    function automatic longint weps();
        longint e;
        e = (ONE + 5000) / 10000;
        return e < 1 ? 1 : e;
    endfunction

    // floor shift: arithmetic shift of a signed longint rounds toward minus infinity
    function automatic bit transform(longint m[16], longint vin[4], output longint vout[4]);
        longint acc;
        for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int c = 0; c < 4; c++)
                acc += (vin[c] * m[c*4+r]) >>> FB;
            if (outside32(acc))
                return 0;
            vout[r] = acc;
        end
        return 1;
    endfunction

    function automatic bit corner_to_screen(longint x, longint y, longint z,
                                            output longint sx, output longint sy);
        longint v[4], e[4], c[4];
        longint w, nx, ny, nz;
        if (vp_w == 0 || vp_h == 0)
            return 0;
        v[0] = x; v[1] = y; v[2] = z; v[3] = ONE;
        if (!transform(mv, v, e))
            return 0;
        if (!transform(pj, e, c))
            return 0;
        w = c[3];
        if ((w < 0 ? -w : w) < weps())
            return 0;
        nx = (c[0] * ONE) / w;
        ny = (c[1] * ONE) / w;
        nz = (c[2] * ONE) / w;
        if (outside32(nx) || outside32(ny) || outside32(nz))
            return 0;
        if (nz < -ONE || nz > ONE)
            return 0;
        sx = (vp_w * (nx + ONE)) >>> 1;
        sy = (vp_h * (ONE - ny)) >>> 1;
        if (outside32(sx) || outside32(sy))
            return 0;
        return 1;
    endfunction

    function automatic logic [OUT_W-1:0] predict_rect(logic [IN_W-1:0] w);
        bsp_mode_t mode;
        logic [3:0] idx;
        longint lo[3], hi[3];
        longint sx, sy, mnx, mny, mxx, mxy;
        int vis;
        bsp_status_t st;
        mode = bsp_mode_t'(w[1:0]);
        idx = w[5:2];
        mnx = 0; mny = 0; mxx = 0; mxy = 0; vis = 0;
        if (mode == MODE_LOAD_MV) begin
            mv[idx] = longint'(signed'(w[37:6]));
            return {2'b00, 128'd0, 4'd0, STAT_LOADED};
        end
        if (mode == MODE_LOAD_PROJ) begin
            pj[idx] = longint'(signed'(w[37:6]));
            return {2'b00, 128'd0, 4'd0, STAT_LOADED};
        end
        for (int k = 0; k < 3; k++) begin
            lo[k] = longint'(signed'(w[38 + 32*k +: 32]));
            hi[k] = longint'(signed'(w[134 + 32*k +: 32]));
        end
        for (int k = 0; k < 8; k++) begin
            if (corner_to_screen(k[0] ? hi[0] : lo[0], k[1] ? hi[1] : lo[1],
                                 k[2] ? hi[2] : lo[2], sx, sy)) begin
                if (vis == 0) begin
                    mnx = sx; mxx = sx; mny = sy; mxy = sy;
                end else begin
                    if (sx < mnx) mnx = sx;
                    if (sx > mxx) mxx = sx;
                    if (sy < mny) mny = sy;
                    if (sy > mxy) mxy = sy;
                end
                vis++;
            end
        end
        if (vis == 0)
            return {2'b00, 128'd0, 4'd0, STAT_NONE};
        st = ((mxx - mnx) < min_size || (mxy - mny) < min_size) ? STAT_SMALL : STAT_VALID;
        return {2'b00, mxy[31:0], mxx[31:0], mny[31:0], mnx[31:0], 4'(vis), st};
    endfunction

    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                mv[i] = 0;
                pj[i] = 0;
            end
            vp_w = VP_W_RST;
            vp_h = VP_H_RST;
            min_size = MINSZ_RST;
            rect_q.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (bsp_cfg_idx_t'(cfg_index))
                    CFG_VP_WIDTH:  vp_w = cfg_wdata[VP_W-1:0];
                    CFG_VP_HEIGHT: vp_h = cfg_wdata[VP_W-1:0];
                    CFG_MIN_SIZE:  min_size = cfg_wdata[MINSZ_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                rect_q = {rect_q, predict_rect(s_tdata)};
            if (m_tvalid && m_tready) begin
                if (rect_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result word %h", m_tdata);
                end else begin
                    want = rect_q.pop_front();
                    if (want !== m_tdata) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: status %0d/%0d vis %0d/%0d rect %h/%h",
                                     want[1:0], m_tdata[1:0], want[5:2], m_tdata[5:2],
                                     want[OUT_W-1:6], m_tdata[OUT_W-1:6]);
                    end
                end
            end
            pending <= rect_q.size();
        end
    end
endmodule
`default_nettype wire

// File: dv/testbench.sv
// top of the box screen projection testbench: stimulus, configuration phases and verdict
`default_nettype none
module testbench;
    import bsp_pkg::*;

    localparam int ONE = 65536;
    localparam int WATCH_LIMIT = 200000;

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [CFG_A_W-1:0] cfg_index;
    logic [CFG_D_W-1:0] cfg_wdata;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [IN_W-1:0] s_tdata;
    logic [OUT_W-1:0] m_tdata;
    int fail_count, pending, idle_cycles, stall_left;

    box_screen_projection DUT (.*);

    bsp_scoreboard checker_i (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // random receiver stalls, mostly short, a few long
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready <= 0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready <= 0;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(0, 2);
        end else
            m_tready <= 1;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int gap_len();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        return n;
    endfunction

    task automatic send_word(logic [IN_W-1:0] w);
        int n;
        s_tdata <= w;
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n = gap_len();
        if (n != 0) begin
            s_tvalid <= 0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // stop sending and wait until every word in flight has come back
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [IN_W-1:0] load_word(bsp_mode_t m, int idx, logic [31:0] v);
        logic [IN_W-1:0] w;
        w = '0;
        w[1:0] = m;
        w[5:2] = idx[3:0];
        w[37:6] = v;
        for (int k = 0; k < 6; k++) w[38 + 32*k +: 32] = $urandom;
        return w;
    endfunction

    function automatic logic [IN_W-1:0] box_word(bsp_mode_t m, int b[6]);
        logic [IN_W-1:0] w;
        w = '0;
        w[1:0] = m;
        w[5:2] = 4'($urandom);
        w[37:6] = $urandom;
        for (int k = 0; k < 6; k++) w[38 + 32*k +: 32] = b[k];
        return w;
    endfunction

    task automatic load_matrix(bsp_mode_t m, int e[16]);
        for (int i = 0; i < 16; i++) send_word(load_word(m, i, e[i]));
    endtask

    // a plausible camera: scaled model-view, offset, rare shear; perspective projection
    task automatic load_camera();
        int mvm[16], pm[16];
        int s;
        mvm = '{default: 0};
        pm = '{default: 0};
        s = $urandom_range(ONE / 4, 2 * ONE);
        mvm[0] = s; mvm[5] = s; mvm[10] = s; mvm[15] = ONE;
        mvm[12] = $urandom_range(0, 8 * ONE) - 4 * ONE;
        mvm[13] = $urandom_range(0, 8 * ONE) - 4 * ONE;
        mvm[14] = -$urandom_range(2 * ONE, 20 * ONE);
        if ($urandom_range(0, 3) == 0) mvm[1] = $urandom_range(0, ONE) - ONE / 2;
        pm[0] = $urandom_range(ONE / 2, 3 * ONE);
        pm[5] = $urandom_range(ONE / 2, 3 * ONE);
        pm[10] = -ONE - $urandom_range(0, ONE / 8);
        pm[14] = -$urandom_range(ONE / 8, ONE / 2);
        pm[11] = -ONE;
        load_matrix(MODE_LOAD_MV, mvm);
        load_matrix(MODE_LOAD_PROJ, pm);
    endtask

    task automatic random_box();
        int b[6];
        int c, h;
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                b[k] = $urandom;
                b[k + 3] = $urandom;
            end else begin
                c = $urandom_range(0, 8 * ONE) - 4 * ONE;
                h = $urandom_range(0, 2 * ONE);
                b[k] = c - h;
                b[k + 3] = c + h;
                if ($urandom_range(0, 15) == 0) begin
                    b[k] = c + h;
                    b[k + 3] = c - h;
                end
            end
        end
        send_word(box_word($urandom_range(0, 4) == 0 ? MODE_BOX_ALT : MODE_BOX, b));
    endtask

    task automatic set_reg(bsp_cfg_idx_t idx, int v);
        drain();
        repeat (20) @(posedge aclk);
        cfg_index <= idx;
        cfg_wdata <= CFG_D_W'(v);
        cfg_wr_en <= 1;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    initial begin
        int b[6];
        int fullm[16];
        s_tvalid = 0;
        s_tdata = '0;
        cfg_wr_en = 0;
        cfg_index = CFG_VP_WIDTH;
        cfg_wdata = '0;
        aresetn = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: box against zero matrices, extreme loads, extreme boxes
        b = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        send_word(box_word(MODE_BOX, b));
        send_word(load_word(MODE_LOAD_MV, 15, 32'h7fffffff));
        send_word(load_word(MODE_LOAD_PROJ, 0, 32'h80000000));
        load_camera();
        send_word(box_word(MODE_BOX, b));
        b = '{-ONE, -ONE, -ONE, ONE, ONE, ONE};
        send_word(box_word(MODE_BOX, b));
        send_word(box_word(MODE_BOX_ALT, b));
        b = '{ONE, ONE, ONE, -ONE, -ONE, -ONE};
        send_word(box_word(MODE_BOX, b));
        b = '{0, 0, 0, 1, 1, 1};
        send_word(box_word(MODE_BOX, b));
        fullm = '{default: 32'sh7fffffff};
        load_matrix(MODE_LOAD_MV, fullm);
        b = '{ONE, ONE, ONE, ONE, ONE, ONE};
        send_word(box_word(MODE_BOX, b));

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                1: set_reg(CFG_VP_WIDTH, 8192);
                2: set_reg(CFG_VP_HEIGHT, 1);
                3: set_reg(CFG_MIN_SIZE, 4194304);
                4: set_reg(CFG_MIN_SIZE, 0);
                5: set_reg(CFG_VP_WIDTH, 0);
                6: begin
                    set_reg(CFG_VP_WIDTH, $urandom_range(1, 8192));
                    set_reg(CFG_VP_HEIGHT, $urandom_range(1, 8192));
                    set_reg(CFG_MIN_SIZE, $urandom_range(0, 4194304));
                end
                7: begin
                    set_reg(CFG_VP_WIDTH, 1);
                    set_reg(CFG_VP_HEIGHT, 8192);
                    set_reg(CFG_MIN_SIZE, (1 << CFG_D_W) - 1);
                end
                default: ;
            endcase
            load_camera();
            for (int i = 0; i < 80; i++) begin
                if ($urandom_range(0, 19) == 0)
                    send_word(load_word(bsp_mode_t'($urandom_range(0, 1)),
                                        $urandom_range(0, 15), $urandom));
                else
                    random_box();
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
